// ===== hdl/aec_pkg.sv =====
`default_nettype none

package aec_pkg;

	localparam int SAMPLE_W = 16;
	localparam int ENV_W = 25;
	localparam int STEP_W = 25;
	localparam int MIX_W = 15;
	localparam int GAIN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 25;
	localparam int DIV_STEPS = GAIN_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_COMPRESS_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN_0 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MIX_GAIN_1 = 3'd4;

	typedef struct packed {
		logic compress_enable;
		logic [STEP_W-1:0] attack_step;
		logic [STEP_W-1:0] release_step;
		logic [MIX_W-1:0] mix_gain_0;
		logic [MIX_W-1:0] mix_gain_1;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ENV,
		S_DINIT,
		S_DIV,
		S_MUL,
		S_COMP,
		S_MIX,
		S_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic env;
		logic dinit;
		logic div;
		logic mul;
		logic comp;
		logic mix;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic out_hold;
	} sts_t;

endpackage

`default_nettype wire

// ===== hdl/aec_regs.sv =====
`default_nettype none

module aec_regs
	import aec_pkg::*;
(
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [CFG_IDX_W-1:0]        cfg_index,
	input  wire  [CFG_DATA_W-1:0]       cfg_wdata,
	output cfg_t                        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.compress_enable <= 1'b1;
			cfg_q.attack_step <= STEP_W'(1748);
			cfg_q.release_step <= STEP_W'(874);
			cfg_q.mix_gain_0 <= MIX_W'(16384);
			cfg_q.mix_gain_1 <= MIX_W'(16384);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COMPRESS_ENABLE: cfg_q.compress_enable <= cfg_wdata[0];
				REG_ATTACK_STEP: cfg_q.attack_step <= cfg_wdata[STEP_W-1:0];
				REG_RELEASE_STEP: cfg_q.release_step <= cfg_wdata[STEP_W-1:0];
				REG_MIX_GAIN_0: cfg_q.mix_gain_0 <= cfg_wdata[MIX_W-1:0];
				REG_MIX_GAIN_1: cfg_q.mix_gain_1 <= cfg_wdata[MIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/aec_ctrl.sv =====
`default_nettype none

module aec_ctrl
	import aec_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   in_valid,
	output logic  in_ready,
	input  sts_t  sts,
	output cmd_t  cmd
);

	state_t state_q, state_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			div_cnt_q <= div_cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		div_cnt_d = div_cnt_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_ENV;
				end
			end
			S_ENV: begin
				cmd.env = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				cmd.dinit = 1'b1;
				div_cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				div_cnt_d = div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_COMP;
			end
			S_COMP: begin
				cmd.comp = 1'b1;
				state_d = S_MIX;
			end
			S_MIX: begin
				cmd.mix = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!sts.out_hold) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> ($past(state_q) == S_DIV && $past(div_cnt_q) == DIV_LAST))
		else $error("multiply started before the divider finished");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !sts.out_hold)
		else $error("result written over a pending output");

endmodule

`default_nettype wire

// ===== hdl/aec_datapath.sv =====
`default_nettype none

module aec_datapath
	import aec_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  cmd_t                         cmd,
	input  cfg_t                         cfg,
	input  wire  signed [SAMPLE_W-1:0]   sample_ch0,
	input  wire  signed [SAMPLE_W-1:0]   sample_ch1,
	input  wire                          out_ready,
	output sts_t                         sts,
	output logic                         out_valid,
	output logic signed [SAMPLE_W-1:0]   out_ch0,
	output logic signed [SAMPLE_W-1:0]   out_ch1,
	output logic [GAIN_W-1:0]            applied_gain
);

	localparam int SAT_W = 40;
	localparam int PROD_W = 2 * (SAMPLE_W + 1);
	localparam int MIXP_W = 2 * SAMPLE_W;
	localparam int RND_SHIFT = 14;
	localparam int TGT_PAD = ENV_W - SAMPLE_W;
	localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(1) << (ENV_W - 1);
	localparam logic [ENV_W-1:0] ENV_HALF = ENV_W'(1) << (ENV_W - 2);
	localparam logic [ENV_W-1:0] REM_BASE = ENV_W'(1) << (38 - GAIN_W);
	localparam logic [MIX_W-1:0] MIX_SKIP_MAX = MIX_W'(1);
	localparam logic signed [SAT_W-1:0] SMAX = SAT_W'((64'sd1 <<< (SAMPLE_W - 1)) - 1);
	localparam logic signed [SAT_W-1:0] SMIN = -SMAX - 1;
	localparam logic [GAIN_W-1:0] GAIN_MIN = GAIN_W'(1) << (GAIN_W - 3);
	localparam logic [GAIN_W-1:0] GAIN_MAX = GAIN_W'(1) << (GAIN_W - 1);

	function automatic logic signed [SAMPLE_W-1:0] sat_s(input logic signed [SAT_W-1:0] v);
		logic signed [SAT_W-1:0] r;
		r = v;
		if (v > SMAX) begin
			r = SMAX;
		end else if (v < SMIN) begin
			r = SMIN;
		end
		return SAMPLE_W'(r);
	endfunction

	logic signed [SAMPLE_W-1:0] s0_q, s1_q, drive_q, comp_q;
	logic [ENV_W-1:0] target_q, env_q, div_d_q, rem_q;
	logic [GAIN_W-1:0] qn_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [MIXP_W-1:0] mixp0_q, mixp1_q;
	logic out_valid_q;
	logic signed [SAMPLE_W-1:0] out_ch0_q, out_ch1_q;
	logic [GAIN_W-1:0] gain_out_q;

	logic [SAMPLE_W-1:0] mag;
	logic signed [SAMPLE_W:0] sum;
	logic [ENV_W-1:0] target_new;
	logic [ENV_W:0] up, dn;
	logic [ENV_W-1:0] env_next, clampv;
	logic [ENV_W:0] r2, r2_sub;
	logic ge;
	logic signed [PROD_W-1:0] prod_rnd;
	logic signed [MIXP_W-1:0] rnd0, rnd1;
	logic signed [SAT_W-1:0] mix_sum0, mix_sum1;

	always_comb begin
		mag = sample_ch0[SAMPLE_W-1] ? (~sample_ch0 + 1'b1) : sample_ch0;
		target_new = {mag, TGT_PAD'(0)};
		sum = {sample_ch0[SAMPLE_W-1], sample_ch0} + {sample_ch1[SAMPLE_W-1], sample_ch1};

		up = {1'b0, env_q} + {1'b0, cfg.attack_step};
		dn = {1'b0, env_q} - {1'b0, cfg.release_step};
		env_next = env_q;
		if (target_q > env_q) begin
			env_next = (up < {1'b0, target_q}) ? up[ENV_W-1:0] : target_q;
		end else if (target_q < env_q) begin
			env_next = (!dn[ENV_W] && dn[ENV_W-1:0] > target_q) ? dn[ENV_W-1:0] : target_q;
		end

		clampv = (env_q < ENV_HALF) ? ENV_HALF : env_q;

		r2 = {rem_q, qn_q[GAIN_W-1]};
		r2_sub = r2 - {1'b0, div_d_q};
		ge = r2 >= {1'b0, div_d_q};

		prod_rnd = (prod_q + PROD_W'(8192)) >>> RND_SHIFT;
		rnd0 = (mixp0_q + MIXP_W'(8192)) >>> RND_SHIFT;
		rnd1 = (mixp1_q + MIXP_W'(8192)) >>> RND_SHIFT;
		mix_sum0 = SAT_W'(s0_q) + SAT_W'(rnd0);
		mix_sum1 = SAT_W'(s1_q) + SAT_W'(rnd1);
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s0_q <= sample_ch0;
			s1_q <= sample_ch1;
			drive_q <= cfg.compress_enable ? sample_ch0 : sum[SAMPLE_W:1];
			target_q <= cfg.compress_enable ? target_new : ENV_ONE;
		end
		if (cmd.dinit) begin
			div_d_q <= clampv;
			rem_q <= REM_BASE | ENV_W'(clampv[ENV_W-1:GAIN_W+1]);
			qn_q <= clampv[GAIN_W:1];
		end
		if (cmd.div) begin
			rem_q <= ge ? r2_sub[ENV_W-1:0] : r2[ENV_W-1:0];
			qn_q <= {qn_q[GAIN_W-2:0], ge};
		end
		if (cmd.mul) begin
			prod_q <= $signed({1'b0, qn_q}) * $signed({drive_q[SAMPLE_W-1], drive_q});
		end
		if (cmd.comp) begin
			comp_q <= sat_s(SAT_W'(prod_rnd));
		end
		if (cmd.mix) begin
			mixp0_q <= $signed({1'b0, cfg.mix_gain_0}) * comp_q;
			mixp1_q <= $signed({1'b0, cfg.mix_gain_1}) * comp_q;
		end
		if (cmd.fin) begin
			out_ch0_q <= (cfg.mix_gain_0 <= MIX_SKIP_MAX) ? s0_q : sat_s(mix_sum0);
			out_ch1_q <= (cfg.mix_gain_1 <= MIX_SKIP_MAX) ? s1_q : sat_s(mix_sum1);
			gain_out_q <= qn_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			env_q <= ENV_ONE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.env) begin
				env_q <= env_next;
			end
			if (cmd.fin) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_hold = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_ch0 = out_ch0_q;
	assign out_ch1 = out_ch1_q;
	assign applied_gain = gain_out_q;

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= ENV_ONE)
		else $error("envelope above unity");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> (qn_q >= GAIN_MIN && qn_q <= GAIN_MAX))
		else $error("reciprocal out of range");

endmodule

`default_nettype wire

// ===== hdl/audio_envelope_compressor_core.sv =====
// Envelope-following compressor for one stereo frame of Q1.15 samples.
// Input channel: in_valid/in_ready carry sample_ch0 and sample_ch1; a frame
// is taken on a clock edge where both are high. Output channel: out_valid/
// out_ready carry out_ch0, out_ch1 and applied_gain, one result per frame.
// The configuration port writes cfg_wdata into register cfg_index whenever
// cfg_we is high; writes are meant for times when no frame is in flight.
// The block works on one frame at a time; most of the time spent on each
// frame goes to the restoring divider that forms the reciprocal gain, one
// quotient bit per cycle.
// A finished result waits in the output register; a new frame may be taken
// and processed meanwhile, and it waits in its last step until the output
// register is free, so a stalled receiver holds back at most one frame.
// Reset clears the envelope to 1.0, the registers to their defaults and
// the output register to empty.

`default_nettype none

module audio_envelope_compressor_core
	import aec_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_we,
	input  wire  [CFG_IDX_W-1:0]         cfg_index,
	input  wire  [CFG_DATA_W-1:0]        cfg_wdata,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  signed [SAMPLE_W-1:0]   sample_ch0,
	input  wire  signed [SAMPLE_W-1:0]   sample_ch1,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic signed [SAMPLE_W-1:0]   out_ch0,
	output logic signed [SAMPLE_W-1:0]   out_ch1,
	output logic [GAIN_W-1:0]            applied_gain
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	aec_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	aec_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	aec_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg),
		.sample_ch0   (sample_ch0),
		.sample_ch1   (sample_ch1),
		.out_ready    (out_ready),
		.sts          (sts),
		.out_valid    (out_valid),
		.out_ch0      (out_ch0),
		.out_ch1      (out_ch1),
		.applied_gain (applied_gain)
	);

endmodule

`default_nettype wire
